// File: rtl/fbc_pkg.sv
// Shared types and constants for the frustum box culling block.
// Holds the packed plane layout, the register index codes and the pipeline
// control word. Depends on nothing.
package fbc_pkg;

  localparam int NUM_PLANES = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int COORD_IN_W = 14;
  localparam int COEF_W     = 11;
  localparam int OFFS_W     = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_LEFT   = 3'd0,
    REG_PLANE_RIGHT  = 3'd1,
    REG_PLANE_BOTTOM = 3'd2,
    REG_PLANE_TOP    = 3'd3,
    REG_PLANE_NEAR   = 3'd4,
    REG_PLANE_FAR    = 3'd5
  } plane_idx_t;

  localparam plane_idx_t PLANE_IDX [NUM_PLANES] = '{
    REG_PLANE_LEFT, REG_PLANE_RIGHT, REG_PLANE_BOTTOM,
    REG_PLANE_TOP, REG_PLANE_NEAR, REG_PLANE_FAR
  };

  typedef struct packed {
    logic signed [OFFS_W-1:0] d;
    logic signed [COEF_W-1:0] c;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] a;
  } plane_t;

  typedef struct packed {
    logic valid;
    logic visible;
  } ctl_t;

endpackage

// File: rtl/frustum_box_cull.sv
// Frustum culling of terrain column boxes against six configured planes.
// Depends on fbc_pkg, fbc_span and fbc_cell.
//
// Each request carries a column index pair and returns exactly one visible
// flag, in order. The block takes one request per cycle while out_ready is
// high. Box bounds are registered in fbc_span on acceptance, then pass stage
// A and stage B in each of six plane cells; the last stage B register is the
// output register. The whole chain advances together, so in_ready follows
// out_ready whenever a result is held. The user must write plane registers
// through the cfg port only while the block is idle; the block itself does
// not enforce this. cfg_ready is always high and indices six and seven are
// ignored. After reset all planes are zero and every box is visible.
module frustum_box_cull #(
  parameter int COLUMN_SIZE   = 32,
  parameter int COLUMN_HEIGHT = 256
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [fbc_pkg::COORD_IN_W-1:0] in_column_x,
  input  logic signed [fbc_pkg::COORD_IN_W-1:0] in_column_z,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_visible,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [fbc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [fbc_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import fbc_pkg::*;

  localparam int CW = 16 + $clog2(COLUMN_SIZE);

  logic                 adv;
  ctl_t                 ctl_c [NUM_PLANES+1];
  logic signed [CW-1:0] xlo_c [NUM_PLANES+1];
  logic signed [CW-1:0] xhi_c [NUM_PLANES+1];
  logic signed [CW-1:0] zlo_c [NUM_PLANES+1];
  logic signed [CW-1:0] zhi_c [NUM_PLANES+1];

  assign adv       = ~ctl_c[NUM_PLANES].valid | out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  fbc_span #(
    .COLUMN_SIZE (COLUMN_SIZE),
    .CW          (CW)
  ) u_span (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .take     (in_valid),
    .column_x (in_column_x),
    .column_z (in_column_z),
    .ctl_o    (ctl_c[0]),
    .xlo_o    (xlo_c[0]),
    .xhi_o    (xhi_c[0]),
    .zlo_o    (zlo_c[0]),
    .zhi_o    (zhi_c[0])
  );

  for (genvar g = 0; g < NUM_PLANES; g++) begin : g_cell
    fbc_cell #(
      .COLUMN_HEIGHT (COLUMN_HEIGHT),
      .CW            (CW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .wr_en   (cfg_valid && (cfg_index == PLANE_IDX[g])),
      .wr_data (cfg_data),
      .ctl_i   (ctl_c[g]),
      .xlo_i   (xlo_c[g]),
      .xhi_i   (xhi_c[g]),
      .zlo_i   (zlo_c[g]),
      .zhi_i   (zhi_c[g]),
      .ctl_o   (ctl_c[g+1]),
      .xlo_o   (xlo_c[g+1]),
      .xhi_o   (xhi_c[g+1]),
      .zlo_o   (zlo_c[g+1]),
      .zhi_o   (zhi_c[g+1])
    );
  end

  assign out_valid   = ctl_c[NUM_PLANES].valid;
  assign out_visible = ctl_c[NUM_PLANES].visible;

endmodule

// File: rtl/fbc_span.sv
// Entry stage: turns a column index pair into the box bounds along x and z.
// Depends on fbc_pkg.
module fbc_span #(
  parameter int COLUMN_SIZE = 32,
  parameter int CW          = 21
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  logic                                 take,
  input  logic signed [fbc_pkg::COORD_IN_W-1:0] column_x,
  input  logic signed [fbc_pkg::COORD_IN_W-1:0] column_z,
  output fbc_pkg::ctl_t                        ctl_o,
  output logic signed [CW-1:0]                 xlo_o,
  output logic signed [CW-1:0]                 xhi_o,
  output logic signed [CW-1:0]                 zlo_o,
  output logic signed [CW-1:0]                 zhi_o
);
  import fbc_pkg::*;

  localparam logic signed [CW-1:0] SIZE_S = CW'(COLUMN_SIZE);

  ctl_t                 ctl_r, ctl_nxt;
  logic signed [CW-1:0] cx_w, cz_w;
  logic signed [CW-1:0] xlo_r, xhi_r, zlo_r, zhi_r;
  logic signed [CW-1:0] xlo_nxt, xhi_nxt, zlo_nxt, zhi_nxt;

  always_comb begin
    cx_w          = CW'(column_x);
    cz_w          = CW'(column_z);
    xlo_nxt       = cx_w * SIZE_S;
    zlo_nxt       = cz_w * SIZE_S;
    xhi_nxt       = xlo_nxt + SIZE_S;
    zhi_nxt       = zlo_nxt + SIZE_S;
    ctl_nxt.valid   = take;
    ctl_nxt.visible = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xlo_r <= xlo_nxt;
      xhi_r <= xhi_nxt;
      zlo_r <= zlo_nxt;
      zhi_r <= zhi_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign xlo_o = xlo_r;
  assign xhi_o = xhi_r;
  assign zlo_o = zlo_r;
  assign zhi_o = zhi_r;

endmodule

// File: rtl/fbc_cell.sv
// One plane cell: holds a plane, tests the passing box against it over two
// stages and hands box and flag to the next cell. Depends on fbc_pkg.
module fbc_cell #(
  parameter int COLUMN_HEIGHT = 256,
  parameter int CW            = 21
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  logic                               wr_en,
  input  logic [fbc_pkg::CFG_DATA_W-1:0]     wr_data,
  input  fbc_pkg::ctl_t                      ctl_i,
  input  logic signed [CW-1:0]               xlo_i,
  input  logic signed [CW-1:0]               xhi_i,
  input  logic signed [CW-1:0]               zlo_i,
  input  logic signed [CW-1:0]               zhi_i,
  output fbc_pkg::ctl_t                      ctl_o,
  output logic signed [CW-1:0]               xlo_o,
  output logic signed [CW-1:0]               xhi_o,
  output logic signed [CW-1:0]               zlo_o,
  output logic signed [CW-1:0]               zhi_o
);
  import fbc_pkg::*;

  localparam int HW = $clog2(COLUMN_HEIGHT) + 2;
  localparam int PW = COEF_W + CW;
  localparam int BW = COEF_W + HW;
  localparam int SW = ((PW > OFFS_W) ? PW : OFFS_W) + 3;
  localparam logic signed [HW-1:0] HEIGHT_S = HW'(COLUMN_HEIGHT);

  plane_t               plane_r;
  ctl_t                 ctl_a_r, ctl_b_r, ctl_b_nxt;
  logic signed [CW-1:0] xsel, zsel;
  logic signed [PW-1:0] pa_nxt, pc_nxt, pa_r, pc_r;
  logic signed [BW-1:0] bt_nxt, bt_r;
  logic signed [OFFS_W-1:0] d_r;
  logic signed [SW-1:0] sum;
  logic signed [CW-1:0] xlo_a_r, xhi_a_r, zlo_a_r, zhi_a_r;
  logic signed [CW-1:0] xlo_b_r, xhi_b_r, zlo_b_r, zhi_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= '0;
    end else if (wr_en) begin
      plane_r <= plane_t'(wr_data);
    end
  end

  // stage A: pick the farthest corner per axis and form the products
  always_comb begin
    xsel   = plane_r.a[COEF_W-1] ? xlo_i : xhi_i;
    zsel   = plane_r.c[COEF_W-1] ? zlo_i : zhi_i;
    pa_nxt = PW'(plane_r.a) * PW'(xsel);
    pc_nxt = PW'(plane_r.c) * PW'(zsel);
    bt_nxt = plane_r.b[COEF_W-1] ? '0 : BW'(plane_r.b) * BW'(HEIGHT_S);
  end

  // stage B: sum and clear the visible flag when the farthest corner is negative
  always_comb begin
    sum               = SW'(pa_r) + SW'(pc_r) + SW'(bt_r) + SW'(d_r);
    ctl_b_nxt.valid   = ctl_a_r.valid;
    ctl_b_nxt.visible = ctl_a_r.visible & ~sum[SW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
    end else if (adv) begin
      ctl_a_r <= ctl_i;
      ctl_b_r <= ctl_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r    <= pa_nxt;
      pc_r    <= pc_nxt;
      bt_r    <= bt_nxt;
      d_r     <= plane_r.d;
      xlo_a_r <= xlo_i;
      xhi_a_r <= xhi_i;
      zlo_a_r <= zlo_i;
      zhi_a_r <= zhi_i;
      xlo_b_r <= xlo_a_r;
      xhi_b_r <= xhi_a_r;
      zlo_b_r <= zlo_a_r;
      zhi_b_r <= zhi_a_r;
    end
  end

  assign ctl_o = ctl_b_r;
  assign xlo_o = xlo_b_r;
  assign xhi_o = xhi_b_r;
  assign zlo_o = zlo_b_r;
  assign zhi_o = zhi_b_r;

endmodule
